>>> rtl/sopes_pkg.sv
package sopes_pkg;

    localparam int STEP_W = 4;

    // step entry point of the clear path in the microprogram
    localparam logic [STEP_W-1:0] STEP_CLEAR = 4'd10;

    typedef enum logic [1:0] {
        REG_GAIN         = 2'd0,
        REG_NATURAL_FREQ = 2'd1,
        REG_DAMPING      = 2'd2,
        REG_STEP_SIZE    = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        MA_NONE,
        MA_DAMP,
        MA_WN,
        MA_COEF_A,
        MA_GAIN,
        MA_W2,
        MA_KW2,
        MA_X2,
        MA_ACC_HI,
        MA_ACC_LO
    } mul_a_sel_t;

    typedef enum logic [2:0] {
        MB_NONE,
        MB_WN,
        MB_X2,
        MB_W2,
        MB_X1,
        MB_DRIVE,
        MB_DT
    } mul_b_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SET_A,
        OP_SET_W2,
        OP_ACC_NEG,
        OP_SET_KW2,
        OP_ACC_SUB,
        OP_ACC_ADD,
        OP_SET_X1,
        OP_HOLD_T,
        OP_SET_X2,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        mul_a_sel_t        a_sel;
        mul_b_sel_t        b_sel;
        dp_op_t            op;
        logic              br_clear;
        logic [STEP_W-1:0] target;
        logic              done;
    } ucode_t;

    typedef struct packed {
        logic   load;
        logic   en;
        ucode_t cw;
    } ctrl_t;

    typedef struct packed {
        logic signed [31:0] gain;
        logic [30:0]        natural_freq;
        logic [30:0]        damping;
        logic [16:0]        step_size;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               hit;
    } sat_t;

    function automatic sat_t sat_s32(input logic signed [51:0] v);
        sat_t r;
        r.value = v[31:0];
        r.hit   = 1'b0;
        if (!v[51] && (|v[50:31])) begin
            r.value = 32'sh7FFF_FFFF;
            r.hit   = 1'b1;
        end else if (v[51] && !(&v[50:31])) begin
            r.value = 32'sh8000_0000;
            r.hit   = 1'b1;
        end
        return r;
    endfunction

    function automatic ucode_t mk(input mul_a_sel_t a, input mul_b_sel_t b, input dp_op_t op,
                                  input logic br, input logic [STEP_W-1:0] tgt,
                                  input logic dn);
        ucode_t w;
        w.a_sel    = a;
        w.b_sel    = b;
        w.op       = op;
        w.br_clear = br;
        w.target   = tgt;
        w.done     = dn;
        return w;
    endfunction

    // microprogram: each stepping step after the first consumes the product of the step before it
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t w;
        unique case (step)
            4'd0:    w = mk(MA_DAMP,   MB_WN,    OP_NONE,    1'b1, STEP_CLEAR, 1'b0);
            4'd1:    w = mk(MA_WN,     MB_WN,    OP_SET_A,   1'b0, '0, 1'b0);
            4'd2:    w = mk(MA_COEF_A, MB_X2,    OP_SET_W2,  1'b0, '0, 1'b0);
            4'd3:    w = mk(MA_GAIN,   MB_W2,    OP_ACC_NEG, 1'b0, '0, 1'b0);
            4'd4:    w = mk(MA_W2,     MB_X1,    OP_SET_KW2, 1'b0, '0, 1'b0);
            4'd5:    w = mk(MA_KW2,    MB_DRIVE, OP_ACC_SUB, 1'b0, '0, 1'b0);
            4'd6:    w = mk(MA_X2,     MB_DT,    OP_ACC_ADD, 1'b0, '0, 1'b0);
            4'd7:    w = mk(MA_ACC_HI, MB_DT,    OP_SET_X1,  1'b0, '0, 1'b0);
            4'd8:    w = mk(MA_ACC_LO, MB_DT,    OP_HOLD_T,  1'b0, '0, 1'b0);
            4'd9:    w = mk(MA_NONE,   MB_NONE,  OP_SET_X2,  1'b0, '0, 1'b1);
            4'd10:   w = mk(MA_NONE,   MB_NONE,  OP_CLEAR,   1'b0, '0, 1'b1);
            default: w = mk(MA_NONE,   MB_NONE,  OP_NONE,    1'b0, '0, 1'b1);
        endcase
        return w;
    endfunction

endpackage

>>> rtl/second_order_plant_euler_step.sv
// A stepping item is accepted and runs 10 microcode steps through one shared 34x33
// multiplier before its result is valid; a clear item runs only the first step and the clear step.
// A new item is taken only once the sequencer is back in idle after the final step of the last one;
// the final step holds while the previous result has not been taken.
// Reset (aresetn low, synchronous): position and velocity zero, registers to their
// defaults, no result pending.
module second_order_plant_euler_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_drive,
    input  logic               s_clear,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_position,
    output logic               m_saturated
);
    import sopes_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;

    sopes_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sopes_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_clear (s_clear),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctrl    (ctrl)
    );

    sopes_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .ctrl        (ctrl),
        .s_drive     (s_drive),
        .m_position  (m_position),
        .m_saturated (m_saturated)
    );

endmodule

>>> rtl/sopes_regs.sv
module sopes_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sopes_pkg::cfg_t    cfg
);
    import sopes_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr;

    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain         <= 32'sd65536;
            cfg_reg.natural_freq <= 31'd65536;
            cfg_reg.damping      <= 31'd45875;
            cfg_reg.step_size    <= 17'd655;
        end else if (wr) begin
            unique case (idx)
                REG_GAIN:         cfg_reg.gain         <= pwdata;
                REG_NATURAL_FREQ: cfg_reg.natural_freq <= pwdata[30:0];
                REG_DAMPING:      cfg_reg.damping      <= pwdata[30:0];
                REG_STEP_SIZE:    cfg_reg.step_size    <= pwdata[16:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_GAIN:         prdata = cfg_reg.gain;
            REG_NATURAL_FREQ: prdata = {1'b0, cfg_reg.natural_freq};
            REG_DAMPING:      prdata = {1'b0, cfg_reg.damping};
            REG_STEP_SIZE:    prdata = {15'b0, cfg_reg.step_size};
        endcase
    end

endmodule

>>> rtl/sopes_sequencer.sv
module sopes_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_clear,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output sopes_pkg::ctrl_t ctrl
);
    import sopes_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              clear_reg, clear_next;
    logic              m_valid_reg, m_valid_next;
    ucode_t            cw;
    logic              accept;
    logic              stall;
    logic              en;

    assign cw      = ucode_rom(step_reg);
    assign s_ready = (state_reg == SEQ_IDLE);
    assign accept  = s_valid && s_ready;
    // the final step waits while the previous result is still held
    assign stall   = cw.done && m_valid_reg && !m_ready;
    assign en      = (state_reg == SEQ_RUN) && !stall;
    assign m_valid = m_valid_reg;

    assign ctrl.load = accept;
    assign ctrl.en   = en;
    assign ctrl.cw   = cw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SEQ_IDLE;
            step_reg    <= '0;
            clear_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clear_reg   <= clear_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        clear_next   = clear_reg;
        m_valid_next = (m_valid_reg && !m_ready) || (en && cw.done);
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    state_next = SEQ_RUN;
                    step_next  = '0;
                    clear_next = s_clear;
                end
            end
            SEQ_RUN: begin
                if (en) begin
                    priority if (cw.br_clear && clear_reg) begin
                        step_next = cw.target;
                    end else if (cw.done) begin
                        state_next = SEQ_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

>>> rtl/sopes_datapath.sv
module sopes_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sopes_pkg::cfg_t    cfg,
    input  sopes_pkg::ctrl_t   ctrl,
    input  logic signed [31:0] s_drive,
    output logic signed [31:0] m_position,
    output logic               m_saturated
);
    import sopes_pkg::*;

    logic signed [31:0] x1_reg, x1_next;
    logic signed [31:0] x2_reg, x2_next;
    logic signed [31:0] drive_reg;
    logic [31:0]        coef_a_reg, coef_a_next;
    logic [31:0]        w2_reg, w2_next;
    logic signed [31:0] kw2_reg, kw2_next;
    logic signed [49:0] acc_reg, acc_next;
    logic signed [51:0] t_reg, t_next;
    logic signed [63:0] p_reg;
    logic               hit_reg, hit_next;
    logic signed [31:0] pos_reg, pos_next;
    logic               sat_reg, sat_next;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [66:0] prod;
    logic [16:0]        dt;
    logic signed [47:0] p_fl16;
    sat_t               s1, s2;

    // dt above 1.0 s is used as 1.0 s
    assign dt     = cfg.step_size[16] ? 17'h10000 : cfg.step_size;
    assign p_fl16 = p_reg[63:16];

    always_comb begin
        unique case (ctrl.cw.a_sel)
            MA_DAMP:   mul_a = {3'b0, cfg.damping};
            MA_WN:     mul_a = {3'b0, cfg.natural_freq};
            MA_COEF_A: mul_a = {2'b0, coef_a_reg};
            MA_GAIN:   mul_a = {{2{cfg.gain[31]}}, cfg.gain};
            MA_W2:     mul_a = {2'b0, w2_reg};
            MA_KW2:    mul_a = {{2{kw2_reg[31]}}, kw2_reg};
            MA_X2:     mul_a = {{2{x2_reg[31]}}, x2_reg};
            MA_ACC_HI: mul_a = acc_reg[49:16];
            MA_ACC_LO: mul_a = {18'b0, acc_reg[15:0]};
            default:   mul_a = '0;
        endcase
        unique case (ctrl.cw.b_sel)
            MB_WN:    mul_b = {2'b0, cfg.natural_freq};
            MB_X2:    mul_b = {x2_reg[31], x2_reg};
            MB_W2:    mul_b = {1'b0, w2_reg};
            MB_X1:    mul_b = {x1_reg[31], x1_reg};
            MB_DRIVE: mul_b = {drive_reg[31], drive_reg};
            MB_DT:    mul_b = {16'b0, dt};
            default:  mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    assign s1 = sat_s32({{20{x1_reg[31]}}, x1_reg} + {{4{p_fl16[47]}}, p_fl16});
    // low half of dx2 times dt, floored, completes the exact product
    assign s2 = sat_s32({{20{x2_reg[31]}}, x2_reg} + t_reg + {35'b0, p_reg[32:16]});

    always_comb begin
        x1_next     = x1_reg;
        x2_next     = x2_reg;
        coef_a_next = coef_a_reg;
        w2_next     = w2_reg;
        kw2_next    = kw2_reg;
        acc_next    = acc_reg;
        t_next      = t_reg;
        hit_next    = hit_reg;
        pos_next    = pos_reg;
        sat_next    = sat_reg;
        unique case (ctrl.cw.op)
            OP_NONE: begin
            end
            OP_SET_A: begin
                coef_a_next = (|p_reg[63:47]) ? 32'hFFFF_FFFF : p_reg[46:15];
            end
            OP_SET_W2: begin
                w2_next = (|p_reg[63:48]) ? 32'hFFFF_FFFF : p_reg[47:16];
            end
            OP_ACC_NEG: begin
                acc_next = -{{2{p_fl16[47]}}, p_fl16};
            end
            OP_SET_KW2: begin
                if (!p_reg[63] && (|p_reg[62:47])) begin
                    kw2_next = 32'sh7FFF_FFFF;
                end else if (p_reg[63] && !(&p_reg[62:47])) begin
                    kw2_next = 32'sh8000_0000;
                end else begin
                    kw2_next = p_reg[47:16];
                end
            end
            OP_ACC_SUB: begin
                acc_next = acc_reg - {{2{p_fl16[47]}}, p_fl16};
            end
            OP_ACC_ADD: begin
                acc_next = acc_reg + {{2{p_fl16[47]}}, p_fl16};
            end
            OP_SET_X1: begin
                x1_next  = s1.value;
                hit_next = s1.hit;
            end
            OP_HOLD_T: begin
                t_next = p_reg[51:0];
            end
            OP_SET_X2: begin
                x2_next  = s2.value;
                pos_next = x1_reg;
                sat_next = hit_reg || s2.hit;
            end
            OP_CLEAR: begin
                x1_next  = '0;
                x2_next  = '0;
                pos_next = '0;
                sat_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
        end else if (ctrl.en) begin
            x1_reg <= x1_next;
            x2_reg <= x2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            drive_reg <= s_drive;
        end
        if (ctrl.en) begin
            p_reg      <= prod[63:0];
            coef_a_reg <= coef_a_next;
            w2_reg     <= w2_next;
            kw2_reg    <= kw2_next;
            acc_reg    <= acc_next;
            t_reg      <= t_next;
            hit_reg    <= hit_next;
            pos_reg    <= pos_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_position  = pos_reg;
    assign m_saturated = sat_reg;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sopes_pkg::*;

    localparam int LIMIT     = 500000;
    localparam int MAX_SHOWN = 10;

    localparam logic signed [95:0] U32_MAX = 96'shFFFF_FFFF;
    localparam logic signed [95:0] S32_MAX = 96'sh7FFF_FFFF;
    localparam logic signed [95:0] S32_MIN = -96'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clear;
    } plant_in_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic               saturated;
    } plant_out_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_drive = '0;
    logic               s_clear = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_position;
    logic               m_saturated;

    plant_in_t  pending_steps[$];
    plant_out_t due_positions[$];

    // predictor copy of the plant and its registers
    cfg_t               cfg;
    logic signed [31:0] plant_x1 = '0;
    logic signed [31:0] plant_x2 = '0;

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int cycles        = 0;
    int err_count     = 0;
    int n_steps       = 0;
    int n_clears      = 0;
    int n_results     = 0;
    int n_sat         = 0;
    int n_settings    = 0;

    always #5 aclk = ~aclk;

    second_order_plant_euler_step DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_drive     (s_drive),
        .s_clear     (s_clear),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_saturated (m_saturated)
    );

    function automatic logic signed [95:0] clip_s32(input logic signed [95:0] v,
                                                     inout logic hit);
        if (v > S32_MAX) begin
            hit = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN) begin
            hit = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // One forward Euler step; >>> on signed operands floors, and 96 bits hold
    // every product exactly.
    function automatic plant_out_t euler_step(input plant_in_t it);
        logic signed [95:0] x1, x2, u, g, wn, z, dt, a, w2, kw2, dx2, nx1, nx2;
        logic               coef_hit;
        plant_out_t         r;
        r.saturated = 1'b0;
        coef_hit    = 1'b0;
        if (it.clear) begin
            plant_x1   = '0;
            plant_x2   = '0;
            r.position = '0;
            return r;
        end
        x1 = plant_x1;
        x2 = plant_x2;
        u  = it.drive;
        g  = $signed(cfg.gain);
        wn = {65'd0, cfg.natural_freq};
        z  = {65'd0, cfg.damping};
        dt = {79'd0, cfg.step_size};
        if (dt > 96'sd65536) dt = 96'sd65536;

        a = (z * wn) >>> 15;
        if (a > U32_MAX) a = U32_MAX;
        w2 = (wn * wn) >>> 16;
        if (w2 > U32_MAX) w2 = U32_MAX;
        // coefficient clipping does not flag saturation
        kw2 = clip_s32((g * w2) >>> 16, coef_hit);

        dx2 = ((kw2 * u) >>> 16) - ((a * x2) >>> 16) - ((w2 * x1) >>> 16);
        nx1 = clip_s32(x1 + ((x2 * dt) >>> 16), r.saturated);
        nx2 = clip_s32(x2 + ((dx2 * dt) >>> 16), r.saturated);

        plant_x1   = nx1[31:0];
        plant_x2   = nx2[31:0];
        r.position = plant_x1;
        return r;
    endfunction

    // sender: predicts on acceptance, then presents the next queued item
    always @(posedge aclk) begin : drive_side
        plant_in_t cur;
        plant_in_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.drive = s_drive;
                cur.clear = s_clear;
                due_positions.push_back(euler_step(cur));
                if (s_clear) n_clears++;
                else n_steps++;
            end
            if (!s_valid || s_ready) begin
                if (pending_steps.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    nxt = pending_steps.pop_front();
                    s_valid <= 1'b1;
                    s_drive <= nxt.drive;
                    s_clear <= nxt.clear;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each accepted result against the oldest prediction
    always @(posedge aclk) begin : result_side
        plant_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (m_saturated) n_sat++;
                if (due_positions.size() == 0) begin
                    if (err_count < MAX_SHOWN)
                        $display("%0t: unexpected result position=%0d saturated=%0b",
                                 $realtime, m_position, m_saturated);
                    err_count++;
                end else begin
                    want = due_positions.pop_front();
                    if (m_position !== want.position || m_saturated !== want.saturated) begin
                        if (err_count < MAX_SHOWN)
                            $display("%0t: result %0d: position %0d/%0d saturated %0b/%0b (exp/got)",
                                     $realtime, n_results, want.position, m_position,
                                     want.saturated, m_saturated);
                        err_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, due_positions.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic cfg_write(input reg_index_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN:         cfg.gain         = val;
            REG_NATURAL_FREQ: cfg.natural_freq = val[30:0];
            REG_DAMPING:      cfg.damping      = val[30:0];
            REG_STEP_SIZE:    cfg.step_size    = val[16:0];
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic [31:0] drv, input logic clr);
        plant_in_t it;
        it.drive = drv;
        it.clear = clr;
        pending_steps.push_back(it);
    endtask

    // runs of steps between occasional clears; the drive is often held to
    // give step responses, else random with a random magnitude
    task automatic queue_random(input int n);
        logic signed [31:0] held;
        int                 r;
        held = '0;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 5) begin
                queue_item($urandom, 1'b1);
            end else begin
                if (r >= 35) held = $signed($urandom) >>> $urandom_range(0, 31);
                queue_item(held, 1'b0);
            end
        end
    endtask

    task automatic drain();
        while (pending_steps.size() != 0 || s_valid || due_positions.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic run_setting(input logic [31:0] g, input logic [31:0] wn,
                               input logic [31:0] dz, input logic [31:0] dt,
                               input int n, input int in_idle, input int out_stall);
        cfg_write(REG_GAIN, g);
        cfg_write(REG_NATURAL_FREQ, wn);
        cfg_write(REG_DAMPING, dz);
        cfg_write(REG_STEP_SIZE, dt);
        n_settings++;
        in_idle_pct   <= in_idle;
        out_stall_pct <= out_stall;
        queue_random(n);
        drain();
    endtask

    initial begin
        cfg.gain         = 32'sd65536;
        cfg.natural_freq = 31'd65536;
        cfg.damping      = 31'd45875;
        cfg.step_size    = 17'd655;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: field extremes and clear with odd drives
        n_settings++;
        queue_item(32'h7FFF_FFFF, 1'b1);
        queue_item(32'h7FFF_FFFF, 1'b0);
        queue_item(32'h7FFF_FFFF, 1'b0);
        queue_item(32'h7FFF_FFFF, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_item(32'h0000_0000, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b0);
        queue_item(32'h0000_0001, 1'b0);
        queue_item(32'h0001_0000, 1'b0);
        queue_item(32'hFFFF_0000, 1'b0);
        queue_item(32'h8000_0000, 1'b1);
        queue_item(32'h0000_0000, 1'b1);
        queue_item(32'h0001_0000, 1'b0);
        queue_random(140);
        drain();

        // everything at its maximum: coefficient and state overflow at once
        cfg_write(REG_GAIN, 32'h7FFF_FFFF);
        cfg_write(REG_NATURAL_FREQ, 32'h7FFF_FFFF);
        cfg_write(REG_DAMPING, 32'h7FFF_FFFF);
        cfg_write(REG_STEP_SIZE, 32'h0001_0000);
        n_settings++;
        in_idle_pct   <= 52;
        out_stall_pct <= 0;
        queue_item(32'h7FFF_FFFF, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_random(100);
        drain();
        // everything at zero, most negative gain
        run_setting(32'h8000_0000, 32'h0, 32'h0, 32'h0, 80, 0, 52);
        // a well-behaved plant: K=2, wn=10, psi=0.5, dt=1ms
        run_setting(32'h0002_0000, 32'h000A_0000, 32'h0000_8000, 32'd66, 250, 37, 37);
        // oversized step, used as one second
        run_setting(32'hFFFE_8000, 32'h0003_0000, 32'h0000_199A, 32'h0001_FFFF,
                    150, 0, 0);
        run_setting($urandom, $urandom, $urandom, $urandom_range(0, 32'h1FFFF),
                    200, 52, 0);
        run_setting(32'h0001_0000, 32'd19660800, 32'h0002_0000, 32'd65537, 150, 0, 52);
        run_setting($urandom_range(0, 8 << 16) - (4 << 16), $urandom_range(0, 20 << 16),
                    $urandom_range(0, 2 << 16), $urandom_range(1, 3277), 300, 37, 37);
        // back to the reset values
        run_setting(32'd65536, 32'd65536, 32'd45875, 32'd655, 100, 0, 0);

        $display("%0d register settings, %0d steps and %0d clears sent, %0d results",
                 n_settings, n_steps, n_clears, n_results);
        $display("%0d results saturated, %0d mismatches", n_sat, err_count);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/sopes_pkg.sv
rtl/sopes_regs.sv
rtl/sopes_sequencer.sv
rtl/sopes_datapath.sv
rtl/second_order_plant_euler_step.sv
bench/tb_top.sv
